// ===== rtl/pwcc_pkg.sv =====
// Package for the polygon wall collision counter.
// Types, widths and register indexes shared by all rtl files; no dependencies.
package pwcc_pkg;

    localparam int CoordWidth  = 16;
    localparam int CountWidth  = 16;
    localparam int RadiusWidth = 15;
    localparam int PaddrWidth  = 1;
    localparam logic [RadiusWidth-1:0] RadiusReset = 15'd240;

    // Register byte addresses
    localparam logic [PaddrWidth-1:0] AddrRadius = 1'b0;

    // Width of the coordinate differences
    localparam int DiffWidth = CoordWidth + 1;
    // Squares and products of differences
    localparam int ProdWidth = 2 * DiffWidth;
    // Sum of two products
    localparam int SumWidth  = ProdWidth + 1;

    typedef logic signed [CoordWidth-1:0] coord_t;
    typedef logic signed [DiffWidth-1:0]  diff_t;
    typedef logic signed [SumWidth-1:0]   sum_t;

    // One edge test queued from the front part to the back part
    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        logic   first;   // start of loop: no edge, clears the hit flag
        logic   last;    // report after this test
    } edge_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DOT,
        ST_CROSS,
        ST_BOUND,
        ST_DONE
    } edge_state_t;

endpackage

// ===== rtl/pwcc_front.sv =====
// Front part: accepts vertex words, tracks first and previous vertex and
// emits edge jobs. Depends on pwcc_pkg.
module pwcc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  pwcc_pkg::coord_t   s_centre_x,
    input  pwcc_pkg::coord_t   s_centre_y,
    input  pwcc_pkg::coord_t   s_corner_x,
    input  pwcc_pkg::coord_t   s_corner_y,
    input  logic               s_last_corner,
    input  logic               s_valid,
    output logic               s_ready,
    output pwcc_pkg::edge_job_t job,
    output logic               job_valid,
    input  logic               job_ready
);
    import pwcc_pkg::*;

    coord_t first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic   started_reg;
    logic   pend_close_reg;          // closing edge still to be issued
    edge_job_t close_job_reg;
    logic   take;

    // Accept only when no closing edge is waiting
    assign s_ready = job_ready && !pend_close_reg;
    assign take    = s_valid && s_ready;

    // Issue the closing edge first, else the current word's edge
    always_comb begin
        if (pend_close_reg) begin
            job       = close_job_reg;
            job_valid = 1'b1;
        end else begin
            job.px    = s_centre_x;
            job.py    = s_centre_y;
            job.sx    = prev_x_reg;
            job.sy    = prev_y_reg;
            job.ex    = s_corner_x;
            job.ey    = s_corner_y;
            job.first = !started_reg;
            job.last  = 1'b0;
            job_valid = s_valid;
        end
    end

    // Track loop vertices
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg    <= 1'b0;
            pend_close_reg <= 1'b0;
        end else begin
            if (pend_close_reg && job_ready) begin
                pend_close_reg <= 1'b0;
            end
            if (take) begin
                started_reg    <= !s_last_corner;
                pend_close_reg <= s_last_corner;
            end
        end
    end

    // Payload holds need no reset
    always_ff @(posedge aclk) begin
        if (take) begin
            prev_x_reg <= s_corner_x;
            prev_y_reg <= s_corner_y;
            if (!started_reg) begin
                first_x_reg <= s_corner_x;
                first_y_reg <= s_corner_y;
            end
            close_job_reg.px    <= s_centre_x;
            close_job_reg.py    <= s_centre_y;
            close_job_reg.sx    <= s_corner_x;
            close_job_reg.sy    <= s_corner_y;
            close_job_reg.ex    <= started_reg ? first_x_reg : s_corner_x;
            close_job_reg.ey    <= started_reg ? first_y_reg : s_corner_y;
            close_job_reg.first <= 1'b0;
            close_job_reg.last  <= 1'b1;
        end
    end

`ifndef ASSERT_OFF
    a_no_take_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_close_reg |-> !take) else $error("word taken over closing edge");
    a_last_sets_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_last_corner |=> pend_close_reg) else $error("closing edge lost");
    a_close_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_close_reg |-> job.last && job_valid) else $error("bad closing job");
`endif

endmodule

// ===== rtl/pwcc_queue.sv =====
// Two-entry queue of edge jobs between front and back parts.
// Depends on pwcc_pkg.
module pwcc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  pwcc_pkg::edge_job_t in_job,
    input  logic                in_valid,
    output logic                in_ready,
    output pwcc_pkg::edge_job_t out_job,
    output logic                out_valid,
    input  logic                out_ready
);
    import pwcc_pkg::*;

    edge_job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_job;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers out of step");
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !pop) else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/pwcc_back.sv =====
// Back part: runs one edge test as a sequence of multiplier steps, folds
// hits per loop and emits the report. Depends on pwcc_pkg.
module pwcc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [pwcc_pkg::RadiusWidth-1:0] radius,
    input  pwcc_pkg::edge_job_t         job,
    input  logic                        job_valid,
    output logic                        job_ready,
    output logic                        m_touching,
    output logic                        m_new_contact,
    output logic [pwcc_pkg::CountWidth-1:0] m_contact_count,
    output logic                        m_valid,
    input  logic                        m_ready
);
    import pwcc_pkg::*;

    localparam int R2Width   = 2 * RadiusWidth;
    localparam int LenWidth  = SumWidth;
    localparam int BndWidth  = R2Width + LenWidth;
    localparam int C2Width   = 2 * SumWidth;
    localparam logic [CountWidth-1:0] CountMax = '1;

    edge_state_t state_reg, state_next;
    edge_job_t   job_reg;
    diff_t vx_reg, vy_reg, wx_reg, wy_reg, ux_reg, uy_reg;
    sum_t  dot_reg, len_reg, dw_reg, du_reg, cross_reg;
    logic [R2Width-1:0]  r2_reg;
    logic [C2Width-1:0]  c2_reg;
    logic [BndWidth-1:0] bnd_reg;
    logic hit_reg, was_reg, out_valid_reg;
    logic touch_reg, fresh_reg;
    logic [CountWidth-1:0] count_reg;
    logic [SumWidth-1:0]   cross_mag;
    logic edge_hit, out_free;

    assign out_free        = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_touching      = touch_reg;
    assign m_new_contact   = fresh_reg;
    assign m_contact_count = count_reg;
    assign cross_mag = cross_reg[SumWidth-1] ? SumWidth'(-cross_reg) : cross_reg;

    // Pick the edge decision from the projection region
    always_comb begin
        if (!(dot_reg > 0)) begin
            edge_hit = dw_reg < $signed({1'b0, r2_reg});
        end else if (!(dot_reg < len_reg)) begin
            edge_hit = du_reg < $signed({1'b0, r2_reg});
        end else begin
            edge_hit = C2Width'(c2_reg) < C2Width'(bnd_reg);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        job_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    state_next = job.first ? ST_IDLE : ST_DIFF;
                end
            end
            ST_DIFF:  state_next = ST_DOT;
            ST_DOT:   state_next = ST_CROSS;
            ST_CROSS: state_next = ST_BOUND;
            ST_BOUND: state_next = ST_DONE;
            ST_DONE: begin
                if (!job_reg.last || out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hit_reg       <= 1'b0;
            was_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Load a new result word, else drop the one taken
            if (state_reg == ST_DONE && job_reg.last && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE && job_valid && job.first) hit_reg <= 1'b0;
            if (state_reg == ST_DONE && (!job_reg.last || out_free)) begin
                if (job_reg.last) begin
                    hit_reg       <= 1'b0;
                    was_reg       <= hit_reg || edge_hit;
                    if ((hit_reg || edge_hit) && !was_reg && count_reg != CountMax)
                        count_reg <= count_reg + 1'b1;
                end else if (edge_hit) begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the products of each step
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                job_reg <= job;
                r2_reg  <= R2Width'(radius) * R2Width'(radius);
            end
            ST_DIFF: begin
                vx_reg <= DiffWidth'(job_reg.ex) - DiffWidth'(job_reg.sx);
                vy_reg <= DiffWidth'(job_reg.ey) - DiffWidth'(job_reg.sy);
                wx_reg <= DiffWidth'(job_reg.px) - DiffWidth'(job_reg.sx);
                wy_reg <= DiffWidth'(job_reg.py) - DiffWidth'(job_reg.sy);
                ux_reg <= DiffWidth'(job_reg.px) - DiffWidth'(job_reg.ex);
                uy_reg <= DiffWidth'(job_reg.py) - DiffWidth'(job_reg.ey);
            end
            ST_DOT: begin
                dot_reg <= SumWidth'(wx_reg * vx_reg) + SumWidth'(wy_reg * vy_reg);
                len_reg <= SumWidth'(vx_reg * vx_reg) + SumWidth'(vy_reg * vy_reg);
            end
            ST_CROSS: begin
                dw_reg    <= SumWidth'(wx_reg * wx_reg) + SumWidth'(wy_reg * wy_reg);
                cross_reg <= SumWidth'(wx_reg * vy_reg) - SumWidth'(wy_reg * vx_reg);
            end
            ST_BOUND: begin
                du_reg  <= SumWidth'(ux_reg * ux_reg) + SumWidth'(uy_reg * uy_reg);
                c2_reg  <= C2Width'(cross_mag) * C2Width'(cross_mag);
                bnd_reg <= BndWidth'(r2_reg) * BndWidth'(len_reg[LenWidth-2:0]);
            end
            ST_DONE: begin
                if (job_reg.last && out_free) begin
                    touch_reg <= hit_reg || edge_hit;
                    fresh_reg <= (hit_reg || edge_hit) && !was_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_fresh_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_contact |-> m_touching) else $error("new contact w/o touch");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("count jumped");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job_ready |-> state_reg == ST_IDLE) else $error("ready while busy");
`endif

endmodule

// ===== rtl/polygon_wall_collision_counter.sv =====
// Top level of the polygon wall collision counter: APB register, front,
// queue and back parts. Depends on pwcc_pkg, pwcc_front, pwcc_queue, pwcc_back.
//
//  channel | handshake          | words
//  s_      | s_valid / s_ready  | centre, corner, last_corner
//  m_      | m_valid / m_ready  | touching, new_contact, contact_count
//  apb     | psel&penable&pwrite| radius at byte address 0
//
// Each edge test runs through the back part's steps (diff, dot, cross, bound,
// done); a vertex word costs one test, the last word two (the closing edge).
// The first word of a loop runs no test. The queue lets the front take
// words while the back works. Reset is synchronous, active low; radius
// resets to 240. A waiting result stalls the back only on a loop's end.
module polygon_wall_collision_counter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pwcc_pkg::PaddrWidth-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic signed [pwcc_pkg::CoordWidth-1:0] s_centre_x,
    input  logic signed [pwcc_pkg::CoordWidth-1:0] s_centre_y,
    input  logic signed [pwcc_pkg::CoordWidth-1:0] s_corner_x,
    input  logic signed [pwcc_pkg::CoordWidth-1:0] s_corner_y,
    input  logic                               s_last_corner,
    input  logic                               s_valid,
    output logic                               s_ready,
    output logic                               m_touching,
    output logic                               m_new_contact,
    output logic [pwcc_pkg::CountWidth-1:0]    m_contact_count,
    output logic                               m_valid,
    input  logic                               m_ready
);
    import pwcc_pkg::*;

    logic [RadiusWidth-1:0] radius_reg;
    edge_job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;

    assign pready = 1'b1;
    // Read back the radius
    always_comb begin
        prdata = '0;
        if (paddr == AddrRadius) prdata = 32'(radius_reg);
    end

    // Write the radius
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RadiusReset;
        end else if (psel && penable && pwrite && paddr == AddrRadius) begin
            radius_reg <= pwdata[RadiusWidth-1:0];
        end
    end

    pwcc_front u_front (
        .aclk, .aresetn,
        .s_centre_x, .s_centre_y, .s_corner_x, .s_corner_y, .s_last_corner,
        .s_valid, .s_ready,
        .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
    );

    pwcc_queue u_queue (
        .aclk, .aresetn,
        .in_job(f_job), .in_valid(f_valid), .in_ready(f_ready),
        .out_job(q_job), .out_valid(q_valid), .out_ready(q_ready)
    );

    pwcc_back u_back (
        .aclk, .aresetn, .radius(radius_reg),
        .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
        .m_touching, .m_new_contact, .m_contact_count, .m_valid, .m_ready
    );

endmodule

// ===== tb/sv/polygon_wall_collision_counter_tb.sv =====
// Testbench for polygon_wall_collision_counter: directed and random wall loops,
// checked against an integer edge-distance predictor. Depends on pwcc_pkg and the rtl.
`timescale 1ns / 100ps

module polygon_wall_collision_counter_tb;
    import pwcc_pkg::*;

    localparam int  DrainCycles = 300;
    localparam longint CycleLimit = 600000;

    typedef struct {
        bit          touching;
        bit          new_contact;
        logic [15:0] contact_count;
    } contact_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PaddrWidth-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    coord_t s_centre_x = '0, s_centre_y = '0, s_corner_x = '0, s_corner_y = '0;
    logic s_last_corner = 1'b0, s_valid = 1'b0;
    logic s_ready;
    logic m_touching, m_new_contact, m_valid;
    logic [CountWidth-1:0] m_contact_count;
    logic m_ready = 1'b0;

    // predictor state
    longint radius_cfg = RadiusReset;
    longint first_x, first_y, prev_x, prev_y;
    bit loop_open = 0, hit_acc = 0, was_touch = 0;
    longint contacts = 0;
    contact_word_t expected_contacts[$];

    int  mismatches = 0;
    int  words_sent = 0, results_seen = 0, hits_seen = 0;
    longint cycles = 0;
    bit  src_idle = 1, sink_idle = 1;
    bit  hold_req = 0;
    int  hold_len = 0;

    polygon_wall_collision_counter dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d expected %0d (result %0d)",
                 what, got, want, results_seen);
        mismatches++;
    endtask

    // Decide whether the centre lies closer than the radius to segment s-e.
    function automatic bit edge_hits(input longint px, py, sx, sy, ex, ey);
        longint vx, vy, wx, wy, ux, uy, dot, len, crs, r2;
        logic [127:0] c2, bound;
        vx = ex - sx; vy = ey - sy;
        wx = px - sx; wy = py - sy;
        r2 = radius_cfg * radius_cfg;
        dot = wx * vx + wy * vy;
        len = vx * vx + vy * vy;
        if (dot <= 0)
            return (wx * wx + wy * wy) < r2;
        if (dot >= len) begin
            ux = px - ex; uy = py - ey;
            return (ux * ux + uy * uy) < r2;
        end
        crs = wx * vy - wy * vx;
        if (crs < 0)
            crs = -crs;
        c2 = {64'b0, crs} * {64'b0, crs};
        bound = {64'b0, r2} * {64'b0, len};
        return c2 < bound;
    endfunction

    // Advance the predictor by one accepted word.
    function automatic void contact_step(input longint cx, cy, vx, vy, input bit last);
        contact_word_t w;
        if (!loop_open) begin
            first_x = vx; first_y = vy;
            hit_acc = 0;
        end else if (edge_hits(cx, cy, prev_x, prev_y, vx, vy)) begin
            hit_acc = 1;
        end
        prev_x = vx; prev_y = vy;
        loop_open = 1;
        if (!last)
            return;
        if (edge_hits(cx, cy, vx, vy, first_x, first_y))
            hit_acc = 1;
        w.touching = hit_acc;
        w.new_contact = hit_acc && !was_touch;
        if (w.new_contact && contacts < 65535)
            contacts++;
        w.contact_count = contacts[15:0];
        was_touch = hit_acc;
        loop_open = 0;
        hit_acc = 0;
        expected_contacts.insert(expected_contacts.size(), w);
    endfunction

    // Compare each accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        contact_word_t w;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_contacts.size() == 0) begin
                report("unexpected word", 1, 0);
            end else begin
                w = expected_contacts.pop_front();
                if (m_touching) hits_seen++;
                if (m_touching !== w.touching) report("touching", m_touching, w.touching);
                if (m_new_contact !== w.new_contact)
                    report("new_contact", m_new_contact, w.new_contact);
                if (m_contact_count !== w.contact_count)
                    report("contact_count", m_contact_count, w.contact_count);
            end
        end
    end

    // Result side: random stalls, plus a long hold on request.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(negedge aclk);
                hold_req = 0;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Offer one word and hold it until accepted; called at a falling edge.
    task automatic send_word(input longint cx, cy, vx, vy, input bit last);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_centre_x <= coord_t'(cx); s_centre_y <= coord_t'(cy);
        s_corner_x <= coord_t'(vx); s_corner_y <= coord_t'(vy);
        s_last_corner <= last;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        contact_step(longint'(coord_t'(cx)), longint'(coord_t'(cy)),
                     longint'(coord_t'(vx)), longint'(coord_t'(vy)), last);
        words_sent++;
        @(negedge aclk);
    endtask

    // Wait until all results are in and the block has gone quiet.
    task automatic drain;
        s_valid <= 1'b0;
        while (expected_contacts.size() != 0) @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
    endtask

    task automatic write_radius(input int unsigned value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= AddrRadius; pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        radius_cfg = value & 32'h7FFF;
    endtask

    function automatic longint clip(input longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    // One random loop; near loops put corners around the centre to provoke hits.
    task automatic random_loop(input int max_len);
        longint cx, cy, spread;
        int n;
        bit near;
        n = $urandom_range(1, max_len);
        near = $urandom_range(0, 3) != 0;
        cx = $signed(16'($urandom)); cy = $signed(16'($urandom));
        spread = (radius_cfg + 1) * $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                cx = $signed(16'($urandom)); cy = $signed(16'($urandom));
            end
            if (near)
                send_word(cx, cy,
                          clip(cx + $signed(32'($urandom_range(0, 2 * spread))) - spread),
                          clip(cy + $signed(32'($urandom_range(0, 2 * spread))) - spread),
                          i == n - 1);
            else
                send_word(cx, cy, $signed(16'($urandom)), $signed(16'($urandom)),
                          i == n - 1);
        end
    endtask

    task automatic test_directed;
        // single vertex loops: on the point, then far away
        send_word(0, 0, 0, 0, 1);
        send_word(0, 0, 1000, 1000, 1);
        // field extremes
        send_word(-32768, -32768, 32767, 32767, 0);
        send_word(32767, 32767, -32768, -32768, 1);
        send_word(-32768, 32767, -32768, 32767, 1);
        // zero length edge well inside and just inside the radius
        send_word(100, 100, 100, 300, 0);
        send_word(100, 100, 100, 300, 1);
        send_word(100, 100, 100, 339, 0);
        send_word(100, 100, 100, 339, 1);
        // projection before start, past end, and in the middle of an edge
        send_word(0, 0, 100, 0, 0);
        send_word(0, 0, 2000, 0, 1);
        send_word(2100, 0, 0, 0, 0);
        send_word(2100, 0, 2000, 0, 1);
        send_word(1000, 239, 0, 0, 0);
        send_word(1000, 239, 2000, 0, 1);
        send_word(1000, 240, 0, 0, 0);
        send_word(1000, 240, 2000, 0, 1);
        // centre moves within a loop; the edges after the move hit
        send_word(5000, 5000, 0, 0, 0);
        send_word(5000, 5000, 100, 0, 0);
        send_word(0, 100, 0, 200, 1);
        drain();
    endtask

    task automatic test_radius_extremes;
        write_radius(0);
        send_word(0, 0, 0, 0, 1);
        send_word(5, 5, -100, 5, 0);
        send_word(5, 5, 100, 5, 1);
        drain();
        write_radius(32767);
        send_word(-32768, -32768, 32767, 32767, 1);
        send_word(0, 0, -32768, 32767, 0);
        send_word(0, 0, 32767, -32768, 1);
        send_word(100, -200, 32767, 32767, 1);
        drain();
    endtask

    task automatic test_random(input int words);
        int start;
        start = words_sent;
        while (words_sent - start < words) begin
            if ($urandom_range(0, 40) == 0) begin
                drain();
                write_radius($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600));
            end
            random_loop(6);
        end
        drain();
    endtask

    task automatic test_backpressure;
        hold_len = 400;
        hold_req = 1;
        repeat (80) random_loop(3);
        drain();
    endtask

    task automatic test_no_idle;
        src_idle = 0;
        sink_idle = 0;
        write_radius(300);
        repeat (60) random_loop(4);
        drain();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_radius_extremes();
        write_radius(240);
        test_random(1100);
        test_backpressure();
        test_no_idle();
        $display("covered %0d words and %0d loop results, %0d in contact,",
                 words_sent, results_seen, hits_seen);
        $display("across radius settings from zero to full scale with stalls on both sides");
        if (mismatches == 0 && expected_contacts.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== polygon_wall_collision_counter.f =====
rtl/pwcc_pkg.sv
rtl/pwcc_front.sv
rtl/pwcc_queue.sv
rtl/pwcc_back.sv
rtl/polygon_wall_collision_counter.sv
tb/sv/polygon_wall_collision_counter_tb.sv
